// ===== hw/rtl/hhp_pkg.sv =====
// Shared types, constants and result codes for the HTTP header line parser.
package hhp_pkg;

    localparam int MAX_HEADERS = 32;
    localparam int KEY_BYTES   = 64;
    localparam int VALUE_BYTES = 256;

    localparam int KEY_DEPTH = KEY_BYTES - 1;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KLEN_W    = 6;
    localparam int VLEN_W    = 8;
    localparam int SEEN_W    = 6;
    localparam int IDX_W     = 5;
    localparam int KIND_W    = 3;
    localparam int CH_W      = 8;

    localparam logic [KLEN_W-1:0] KEY_MAX = KLEN_W'(KEY_DEPTH);
    localparam logic [VLEN_W-1:0] VAL_MAX = VLEN_W'(VALUE_BYTES - 1);
    localparam logic [SEEN_W-1:0] HDR_MAX = SEEN_W'(MAX_HEADERS);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [KIND_W-1:0] K_KEYCH   = 3'd0;
    localparam logic [KIND_W-1:0] K_KEYDONE = 3'd1;
    localparam logic [KIND_W-1:0] K_VALCH   = 3'd2;
    localparam logic [KIND_W-1:0] K_VALDONE = 3'd3;
    localparam logic [KIND_W-1:0] K_HDRDONE = 3'd4;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;

    // one queue entry: either a single result word or a key release burst
    typedef struct packed {
        logic              is_rel;
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   ch;
        logic [IDX_W-1:0]  idx;
        logic [SEEN_W-1:0] total;
        logic              last;
        logic [KLEN_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [KEY_AW-1:0] addr;
        logic [CH_W-1:0]   data;
    } t_kwr;

endpackage

// ===== hw/rtl/hhp_queue.sv =====
// Short command queue between the parser front end and the result back end.
module hhp_queue
    import hhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW-1:0]   n_wp;
    logic [Q_AW-1:0]   n_rp;
    logic [Q_AW:0]     n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= (Q_AW+1)'(Q_DEPTH);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue count past depth");

    property p_push_room;
        @(posedge i_clk) disable iff (!i_rst_n) (i_push && !i_pop) |-> !o_full;
    endproperty
    a_push_room: assert property (p_push_room) else $error("push into full queue");

    property p_pop_count;
        @(posedge i_clk) disable iff (!i_rst_n)
            (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 1'b1);
    endproperty
    a_pop_count: assert property (p_pop_count) else $error("queue count lost on pop");

endmodule

// ===== hw/rtl/hhp_front.sv =====
// Front end: accepts request bytes, tracks the line phase, fills the key store, queues commands.
module hhp_front
    import hhp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [CH_W-1:0] i_ch,
    input  logic            i_is_end,
    output logic            o_q_push,
    output t_cmd            o_q_data,
    input  logic            i_q_full,
    output t_kwr            o_kwr,
    input  logic            i_rel_done
);

    localparam logic [2:0] PH_SKIP  = 3'd0;
    localparam logic [2:0] PH_LINE  = 3'd1;
    localparam logic [2:0] PH_KEY   = 3'd2;
    localparam logic [2:0] PH_LEAD  = 3'd3;
    localparam logic [2:0] PH_VALUE = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic [2:0]        r_phase,    n_phase;
    logic [KLEN_W-1:0] r_klen,     n_klen;
    logic [VLEN_W-1:0] r_vlen,     n_vlen;
    logic [SEEN_W-1:0] r_seen,     n_seen;
    logic              r_pcr,      n_pcr;
    logic              r_rel_busy, n_rel_busy;
    logic              r_pend_v,   n_pend_v;
    t_cmd              r_pend,     n_pend;

    logic              accept;
    logic              hazard;
    logic [1:0]        nw;
    t_cmd              w0;
    t_cmd              w1;
    logic [SEEN_W-1:0] seen_inc;
    logic              e1;
    logic              e2;
    logic [VLEN_W-1:0] vlen1;

    function automatic t_cmd mk_word(input logic [KIND_W-1:0] kind,
                                     input logic [CH_W-1:0] ch,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [SEEN_W-1:0] total);
        t_cmd w;
        w        = '0;
        w.kind   = kind;
        w.ch     = ch;
        w.idx    = idx;
        w.total  = total;
        return w;
    endfunction

    // hold key bytes back while the back end still reads the store
    assign hazard   = r_rel_busy && (r_phase == PH_LINE || r_phase == PH_KEY);
    assign o_stall  = i_q_full || r_pend_v || hazard;
    assign accept   = i_valid && !o_stall;
    assign seen_inc = r_seen + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_klen  = r_klen;
        n_vlen  = r_vlen;
        n_seen  = r_seen;
        n_pcr   = r_pcr;
        nw      = 2'd0;
        w0      = '0;
        w1      = '0;
        o_kwr   = '0;
        e1      = 1'b0;
        e2      = 1'b0;
        vlen1   = r_vlen;
        if (accept) begin
            if (i_is_end) begin
                if (r_phase == PH_LEAD || r_phase == PH_VALUE) begin
                    w0 = mk_word(K_VALDONE, CH_NUL, r_seen[IDX_W-1:0], '0);
                    w1 = mk_word(K_HDRDONE, CH_NUL, '0, seen_inc);
                    nw = 2'd2;
                end else if (r_phase != PH_DONE) begin
                    w0 = mk_word(K_HDRDONE, CH_NUL, '0, r_seen);
                    nw = 2'd1;
                end
                n_phase = PH_SKIP;
                n_klen  = '0;
                n_vlen  = '0;
                n_seen  = '0;
                n_pcr   = 1'b0;
            end else begin
                unique case (r_phase) inside
                    PH_SKIP: begin
                        if (i_ch == CH_NUL) begin
                            w0      = mk_word(K_HDRDONE, CH_NUL, '0, r_seen);
                            nw      = 2'd1;
                            n_phase = PH_DONE;
                        end else if (i_ch == CH_LF) begin
                            n_phase = PH_LINE;
                        end
                    end
                    PH_LINE, PH_KEY: begin
                        if (r_phase == PH_LINE &&
                            (i_ch == CH_NUL || i_ch == CH_CR || i_ch == CH_LF)) begin
                            w0      = mk_word(K_HDRDONE, CH_NUL, '0, r_seen);
                            nw      = 2'd1;
                            n_phase = PH_DONE;
                        end else if (i_ch == CH_NUL) begin
                            w0      = mk_word(K_HDRDONE, CH_NUL, '0, r_seen);
                            nw      = 2'd1;
                            n_phase = PH_DONE;
                        end else if (i_ch == CH_LF) begin
                            n_klen  = '0;
                            n_phase = PH_LINE;
                        end else if (i_ch == CH_COLON) begin
                            w0        = mk_word(K_KEYDONE, CH_NUL, r_seen[IDX_W-1:0], '0);
                            w0.is_rel = 1'b1;
                            w0.len    = (r_phase == PH_LINE) ? '0 : r_klen;
                            nw        = 2'd1;
                            n_klen    = '0;
                            n_vlen    = '0;
                            n_pcr     = 1'b0;
                            n_phase   = PH_LEAD;
                        end else begin
                            n_phase = PH_KEY;
                            if (r_phase == PH_LINE) begin
                                o_kwr.we   = 1'b1;
                                o_kwr.addr = '0;
                                o_kwr.data = i_ch;
                                n_klen     = KLEN_W'(1);
                            end else if (r_klen < KEY_MAX) begin
                                o_kwr.we   = 1'b1;
                                o_kwr.addr = r_klen[KEY_AW-1:0];
                                o_kwr.data = i_ch;
                                n_klen     = r_klen + 1'b1;
                            end
                        end
                    end
                    PH_LEAD, PH_VALUE: begin
                        if (!(r_phase == PH_LEAD && i_ch == CH_SPACE)) begin
                            n_phase = PH_VALUE;
                            if (i_ch == CH_NUL) begin
                                w0      = mk_word(K_VALDONE, CH_NUL, r_seen[IDX_W-1:0], '0);
                                w1      = mk_word(K_HDRDONE, CH_NUL, '0, seen_inc);
                                nw      = 2'd2;
                                n_seen  = seen_inc;
                                n_pcr   = 1'b0;
                                n_phase = PH_DONE;
                            end else if (i_ch == CH_LF) begin
                                w0     = mk_word(K_VALDONE, CH_NUL, r_seen[IDX_W-1:0], '0);
                                nw     = 2'd1;
                                n_seen = seen_inc;
                                n_pcr  = 1'b0;
                                if (seen_inc >= HDR_MAX) begin
                                    w1      = mk_word(K_HDRDONE, CH_NUL, '0, seen_inc);
                                    nw      = 2'd2;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_LINE;
                                end
                            end else begin
                                // a held CR becomes a value char if a non-LF/NUL byte follows
                                e1    = r_pcr && (r_vlen < VAL_MAX);
                                vlen1 = r_vlen + VLEN_W'(e1);
                                e2    = (i_ch != CH_CR) && (vlen1 < VAL_MAX);
                                n_pcr = (i_ch == CH_CR);
                                if (e1) begin
                                    w0 = mk_word(K_VALCH, CH_CR, r_seen[IDX_W-1:0], '0);
                                    w1 = mk_word(K_VALCH, i_ch, r_seen[IDX_W-1:0], '0);
                                    nw = e2 ? 2'd2 : 2'd1;
                                end else if (e2) begin
                                    w0 = mk_word(K_VALCH, i_ch, r_seen[IDX_W-1:0], '0);
                                    nw = 2'd1;
                                end
                                n_vlen = vlen1 + VLEN_W'(e2);
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
        if (nw == 2'd1) begin
            w0.last = 1'b1;
        end
        if (nw == 2'd2) begin
            w1.last = 1'b1;
        end
    end

    always_comb begin
        o_q_push   = (r_pend_v && !i_q_full) || (accept && nw != 2'd0);
        o_q_data   = r_pend_v ? r_pend : w0;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_rel_busy = r_rel_busy;
        if (accept && nw == 2'd2) begin
            n_pend   = w1;
            n_pend_v = 1'b1;
        end else if (r_pend_v && !i_q_full) begin
            n_pend_v = 1'b0;
        end
        if (accept && nw != 2'd0 && w0.is_rel) begin
            n_rel_busy = 1'b1;
        end else if (i_rel_done) begin
            n_rel_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SKIP;
            r_klen     <= '0;
            r_vlen     <= '0;
            r_seen     <= '0;
            r_pcr      <= 1'b0;
            r_rel_busy <= 1'b0;
            r_pend_v   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_klen     <= n_klen;
            r_vlen     <= n_vlen;
            r_seen     <= n_seen;
            r_pcr      <= n_pcr;
            r_rel_busy <= n_rel_busy;
            r_pend_v   <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    property p_no_write_in_release;
        @(posedge i_clk) disable iff (!i_rst_n) o_kwr.we |-> !r_rel_busy;
    endproperty
    a_no_write_in_release: assert property (p_no_write_in_release)
        else $error("key store written during release");

    property p_klen_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_klen <= KEY_MAX;
    endproperty
    a_klen_range: assert property (p_klen_range) else $error("key length past store");

    property p_seen_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_seen <= HDR_MAX;
    endproperty
    a_seen_range: assert property (p_seen_range) else $error("header count past limit");

endmodule

// ===== hw/rtl/hhp_back.sv =====
// Back end: key store, key release sequencer and the result output register.
module hhp_back
    import hhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_kwr              i_kwr,
    input  t_cmd              i_head,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    output logic              o_rel_done,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [CH_W-1:0]   o_out_char,
    output logic [IDX_W-1:0]  o_header_index,
    output logic [SEEN_W-1:0] o_header_total,
    output logic              o_run_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;
    localparam logic [1:0] ST_KD   = 2'd3;

    logic [CH_W-1:0]   r_key [KEY_DEPTH];
    logic [CH_W-1:0]   r_rd_data;
    logic [1:0]        r_state, n_state;
    logic [KLEN_W-1:0] r_cnt,   n_cnt;
    logic [KLEN_W-1:0] r_len,   n_len;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic              r_o_valid;
    logic [KIND_W-1:0] r_kind;
    logic [CH_W-1:0]   r_char;
    logic [IDX_W-1:0]  r_index;
    logic [SEEN_W-1:0] r_total;
    logic              r_last;

    logic              slot_free;
    logic              rd_en;
    logic              load;
    t_cmd              ld;

    assign slot_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_idx      = r_idx;
        o_q_pop    = 1'b0;
        o_rel_done = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;
        ld         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head.is_rel) begin
                        o_q_pop = 1'b1;
                        n_len   = i_head.len;
                        n_idx   = i_head.idx;
                        n_cnt   = '0;
                        n_state = (i_head.len == '0) ? ST_KD : ST_RD;
                    end else if (slot_free) begin
                        o_q_pop = 1'b1;
                        load    = 1'b1;
                        ld      = i_head;
                    end
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                if (slot_free) begin
                    load     = 1'b1;
                    ld.kind  = K_KEYCH;
                    ld.ch    = r_rd_data;
                    ld.idx   = r_idx;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = (n_cnt < r_len) ? ST_RD : ST_KD;
                end
            end
            ST_KD: begin
                if (slot_free) begin
                    load       = 1'b1;
                    ld.kind    = K_KEYDONE;
                    ld.idx     = r_idx;
                    ld.last    = 1'b1;
                    o_rel_done = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_len     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (load) begin
            r_kind  <= ld.kind;
            r_char  <= ld.ch;
            r_index <= ld.idx;
            r_total <= ld.total;
            r_last  <= ld.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_kwr.we) begin
            r_key[i_kwr.addr] <= i_kwr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_key[r_cnt[KEY_AW-1:0]];
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_kind;
    assign o_out_char     = r_char;
    assign o_header_index = r_index;
    assign o_header_total = r_total;
    assign o_run_last     = r_last;

    property p_read_in_range;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == ST_RD) |-> (r_cnt < r_len);
    endproperty
    a_read_in_range: assert property (p_read_in_range) else $error("key read past length");

    property p_wr_after_rd;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_WR) |-> ($past(r_state) == ST_RD || $past(r_state) == ST_WR);
    endproperty
    a_wr_after_rd: assert property (p_wr_after_rd) else $error("key char without read");

    property p_done_is_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_o_valid && (r_kind == K_KEYDONE || r_kind == K_HDRDONE)) |-> r_last;
    endproperty
    a_done_is_last: assert property (p_done_is_last) else $error("done mark not last");

endmodule

// ===== hw/rtl/http_header_line_parser.sv =====
// Top level of the HTTP header line parser: front end, command queue, back end.
//
//   channel  direction  handshake           word
//   input    in         i_valid / o_stall   i_ch, i_is_end
//   output   out        o_valid / i_stall   o_kind, o_out_char, o_header_index,
//                                           o_header_total, o_run_last
//
// A byte that yields two results (a held CR plus a char, value done plus headers done)
// parks the second in a pending register and stalls the input until it is queued.
// At a colon the back end pops the release command, then releases each kept key char
// through the key store read register and then the output register, then key done.
// Key bytes of the next line wait until that release is finished.
// Reset clears all control state; the key store is not cleared.
// Either side may stall; the four-entry command queue and the output register hold words.
module http_header_line_parser
    import hhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CH_W-1:0]   i_ch,
    input  logic              i_is_end,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [CH_W-1:0]   o_out_char,
    output logic [IDX_W-1:0]  o_header_index,
    output logic [SEEN_W-1:0] o_header_total,
    output logic              o_run_last
);

    logic q_push;
    t_cmd q_data;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_head;
    t_kwr kwr;
    logic rel_done;

    hhp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ch       (i_ch),
        .i_is_end   (i_is_end),
        .o_q_push   (q_push),
        .o_q_data   (q_data),
        .i_q_full   (q_full),
        .o_kwr      (kwr),
        .i_rel_done (rel_done)
    );

    hhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    hhp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kwr          (kwr),
        .i_head         (q_head),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_rel_done     (rel_done),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_out_char     (o_out_char),
        .o_header_index (o_header_index),
        .o_header_total (o_header_total),
        .o_run_last     (o_run_last)
    );

endmodule
